/* src/fee_pkg.sv */
// Shared types and codes of the flash EEPROM emulation block.
package fee_pkg;

  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_FORMAT = 2'd2;
  localparam logic [1:0] FUNC_MOUNT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd3;
  localparam logic [2:0] ST_RESERVED  = 3'd4;

  localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_APPEND,
    S_SW_CHK,
    S_SW_CHK2,
    S_SW_ERO,
    S_SW_KEY,
    S_SW_KEYW,
    S_SW_SCAN,
    S_SW_PUT,
    S_SW_ERW,
    S_SW_END,
    S_FMT,
    S_MNT
  } fee_state_e;

  typedef struct packed {
    logic [31:0] rd_value;
    logic [2:0]  status;
    logic        swapped;
  } fee_result_t;

endpackage

/* src/flash_eeprom_emulation_top.sv */
// Two-page log-structured key/value store held in one synchronous record memory.
//
// Input channel (in_valid_i/in_ready_o) carries func_i, key_i and write_data_i;
// every transfer gives exactly one result on the output channel
// (out_valid_o/out_ready_i): rd_value_o, status_o and swapped_o.
// The default value register is written through default_value_we_i.
// After reset the record memory is swept to all ones, one slot per cycle;
// in_ready_o stays low during that pass.
// A read or write of a non-reserved key scans the working page through the
// memory read port, one slot per cycle, and a write that changes the value
// then appends a record. A write into a full page compacts it: each slot
// starts a scan of the page, and up to two pages are erased. Format sweeps
// both pages; mount scans one page.
// One item is worked on at a time. The result sits in an output register, so
// the next item is accepted while a stalled result waits; a further result is
// held back until the receiver takes the previous one.
module flash_eeprom_emulation_top #(
  parameter int RECORD_SLOTS = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        default_value_we_i,
  input  logic [31:0] default_value_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] rd_value_o,
  output logic [2:0]  status_o,
  output logic        swapped_o
);
  import fee_pkg::*;

  localparam int DEPTH = 2 * RECORD_SLOTS;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(RECORD_SLOTS + 1);
  localparam logic [AW-1:0] RS_A = AW'(RECORD_SLOTS);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [SW-1:0] RS_S = SW'(RECORD_SLOTS);
  localparam logic [SW-1:0] RS_LAST = SW'(RECORD_SLOTS - 1);

  function automatic logic [AW-1:0] slot_addr(input logic pg, input logic [SW-1:0] s);
    logic [AW-1:0] a;
    a = AW'(s);
    return pg ? RS_A + a : a;
  endfunction

  fee_state_e state_q, state_d;

  logic [1:0]    func_q, func_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   data_q, data_d;
  logic [31:0]   dflt_q;
  logic          wpage_q, wpage_d;
  logic [SW-1:0] fill_q, fill_d;
  logic [31:0]   cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic [SW-1:0] j_q, j_d, jd_q, jd_d;
  logic          pend_q, pend_d;
  logic          found_q, found_d, seen_q, seen_d;
  logic [31:0]   val_q, val_d, kcur_q, kcur_d;
  logic [SW-1:0] i_q, i_d, ocnt_q, ocnt_d;
  logic [AW-1:0] ea_q, ea_d;
  fee_result_t   res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [63:0]   rec_mem [DEPTH];
  logic [63:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata;

  logic          scanning, scan_issue, scan_done;
  logic [SW-1:0] scan_lim;
  logic [31:0]   rkey, rval, cur, cmax;
  logic          opg, in_xfer, out_load, mnt_pg;

  assign rkey = rdata_q[63:32];
  assign rval = rdata_q[31:0];
  assign opg = ~wpage_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer = in_valid_i && in_ready_o;
  assign out_load = !out_valid_q || out_ready_i;
  assign cur = found_q ? val_q : dflt_q;
  assign cmax = ((cnt0_q > cnt1_q) ? cnt0_q : cnt1_q) + 32'd1;
  assign mnt_pg = ((cnt0_q == EMPTY_WORD || cnt1_q == EMPTY_WORD) &&
                   (cnt0_q == 32'd0 || cnt1_q == 32'd0)) ? !(cnt0_q > cnt1_q)
                                                         : !(cnt0_q < cnt1_q);

  assign out_valid_o = out_valid_q;
  assign rd_value_o  = out_q.rd_value;
  assign status_o    = out_q.status;
  assign swapped_o   = out_q.swapped;

  // Page scan: one read issued per cycle, data consumed in the next cycle.
  always_comb begin
    scanning   = (state_q == S_LOOK) || (state_q == S_SW_SCAN) || (state_q == S_MNT);
    scan_lim   = (state_q == S_MNT) ? RS_S : fill_q;
    scan_issue = scanning && (j_q < scan_lim);
    scan_done  = !scan_issue && !pend_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (ea_q == CLR_LAST) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if ((func_i == FUNC_READ || func_i == FUNC_WRITE) && key_i == EMPTY_WORD) begin
            state_d = S_DECIDE;
          end else if (func_i == FUNC_FORMAT) begin
            state_d = S_FMT;
          end else if (func_i == FUNC_MOUNT) begin
            state_d = S_MNT;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK:    if (scan_done) state_d = S_DECIDE;
      S_DECIDE: begin
        if (func_q == FUNC_WRITE && key_q != EMPTY_WORD && cur != data_q) begin
          state_d = (fill_q >= RS_S) ? S_SW_CHK : S_APPEND;
        end else if (out_load) begin
          state_d = S_IDLE;
        end
      end
      S_APPEND:  state_d = S_DECIDE;
      S_SW_CHK:  state_d = S_SW_CHK2;
      S_SW_CHK2: state_d = (rdata_q != '1) ? S_SW_ERO : S_SW_KEY;
      S_SW_ERO:  if (j_q == RS_LAST) state_d = S_SW_KEY;
      S_SW_KEY:  state_d = (i_q == fill_q) ? S_SW_ERW : S_SW_KEYW;
      S_SW_KEYW: state_d = S_SW_SCAN;
      S_SW_SCAN: if (scan_done) state_d = S_SW_PUT;
      S_SW_PUT:  state_d = S_SW_KEY;
      S_SW_ERW:  if (j_q == RS_LAST) state_d = S_SW_END;
      S_SW_END:  state_d = (ocnt_q < RS_S) ? S_APPEND : S_DECIDE;
      S_FMT:     if (ea_q == CLR_LAST) state_d = S_DECIDE;
      S_MNT:     if (scan_done) state_d = S_DECIDE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control. Work that ends in S_DECIDE with the write data
  // matching the current value, or with no write pending, delivers the result once the output register is free.
  always_comb begin
    func_d = func_q; key_d = key_q; data_d = data_q;
    wpage_d = wpage_q; fill_d = fill_q; cnt0_d = cnt0_q; cnt1_d = cnt1_q;
    j_d = j_q; jd_d = jd_q; pend_d = 1'b0;
    found_d = found_q; seen_d = seen_q; val_d = val_q; kcur_d = kcur_q;
    i_d = i_q; ocnt_d = ocnt_q; ea_d = ea_q;
    res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we = 1'b0; waddr = '0; wdata = '1; raddr = '0;

    if (scan_issue) begin
      raddr  = slot_addr(wpage_q, j_q);
      j_d    = j_q + SW'(1);
      pend_d = 1'b1;
      jd_d   = j_q;
    end

    case (state_q)
      S_CLEAR, S_FMT: begin
        mem_we = 1'b1;
        waddr  = ea_q;
        ea_d   = ea_q + AW'(1);
        if (ea_q == CLR_LAST && state_q == S_FMT) begin
          cnt0_d = 32'd0;
          cnt1_d = 32'd1;
          fill_d = '0;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          func_d = func_i; key_d = key_i; data_d = write_data_i;
          j_d = '0; found_d = 1'b0; ea_d = '0;
          res_d = '{rd_value: 32'd0, status: ST_OK, swapped: 1'b0};
          if ((func_i == FUNC_READ || func_i == FUNC_WRITE) && key_i == EMPTY_WORD) begin
            res_d.status = ST_RESERVED;
            if (func_i == FUNC_READ) res_d.rd_value = dflt_q;
          end else if (func_i == FUNC_MOUNT) begin
            wpage_d = mnt_pg;
            fill_d  = RS_S;
          end
        end
      end
      S_LOOK: begin
        if (pend_q && rkey == key_q) begin
          found_d = 1'b1;
          val_d   = rval;
        end
      end
      S_DECIDE: begin
        if (func_q == FUNC_READ && key_q != EMPTY_WORD) begin
          res_d.rd_value = cur;
          res_d.status   = found_q ? ST_OK : ST_NOT_FOUND;
        end
        if (func_q == FUNC_WRITE && key_q != EMPTY_WORD && cur != data_q) begin
          if (fill_q >= RS_S) res_d.swapped = 1'b1;
        end else if (out_load) begin
          out_d       = res_d;
          out_valid_d = 1'b1;
        end
      end
      S_APPEND: begin
        mem_we  = 1'b1;
        waddr   = slot_addr(wpage_q, fill_q);
        wdata   = {key_q, data_q};
        fill_d  = fill_q + SW'(1);
        val_d   = data_q;
        found_d = 1'b1;
      end
      S_SW_CHK: raddr = slot_addr(opg, '0);
      S_SW_CHK2: begin
        j_d = '0; i_d = '0; ocnt_d = '0;
        // A page holds its records as a prefix, so slot 0 tells whether it is dirty.
        if (rdata_q != '1) begin
          if (opg) cnt1_d = cnt0_q + 32'd1;
          else     cnt0_d = cnt1_q + 32'd1;
        end
      end
      S_SW_ERO: begin
        mem_we = 1'b1;
        waddr  = slot_addr(opg, j_q);
        j_d    = j_q + SW'(1);
      end
      S_SW_KEY: begin
        raddr = slot_addr(wpage_q, i_q);
        j_d   = '0;
      end
      S_SW_KEYW: begin
        kcur_d = rkey;
        seen_d = 1'b0;
        val_d  = 32'd0;
      end
      S_SW_SCAN: begin
        if (pend_q && rkey == kcur_q) begin
          val_d = rval;
          if (jd_q < i_q) seen_d = 1'b1;
        end
      end
      S_SW_PUT: begin
        if (!seen_q) begin
          mem_we = 1'b1;
          waddr  = slot_addr(opg, ocnt_q);
          wdata  = {kcur_q, val_q};
          ocnt_d = ocnt_q + SW'(1);
        end
        i_d = i_q + SW'(1);
      end
      S_SW_ERW: begin
        mem_we = 1'b1;
        waddr  = slot_addr(wpage_q, j_q);
        j_d    = j_q + SW'(1);
      end
      S_SW_END: begin
        if (wpage_q) cnt1_d = cmax;
        else         cnt0_d = cmax;
        wpage_d = opg;
        fill_d  = ocnt_q;
        if (ocnt_q >= RS_S) begin
          res_d.status = ST_FULL;
          found_d = 1'b1;
          val_d   = data_q;
        end
      end
      S_MNT: begin
        if (pend_q && !found_q && rkey == EMPTY_WORD) begin
          found_d = 1'b1;
          fill_d  = jd_q;
        end
        if (scan_done) begin
          // Reuse the decide step as a plain result delivery.
          func_d  = FUNC_FORMAT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) rec_mem[waddr] <= wdata;
    rdata_q <= rec_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= 32'd0;
    end else if (default_value_we_i) begin
      dflt_q <= default_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wpage_q     <= 1'b0;
      fill_q      <= '0;
      cnt0_q      <= 32'd0;
      cnt1_q      <= 32'd1;
      j_q         <= '0;
      pend_q      <= 1'b0;
      i_q         <= '0;
      ocnt_q      <= '0;
      ea_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpage_q     <= wpage_d;
      fill_q      <= fill_d;
      cnt0_q      <= cnt0_d;
      cnt1_q      <= cnt1_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      i_q         <= i_d;
      ocnt_q      <= ocnt_d;
      ea_q        <= ea_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    key_q   <= key_d;
    data_q  <= data_d;
    jd_q    <= jd_d;
    found_q <= found_d;
    seen_q  <= seen_d;
    val_q   <= val_d;
    kcur_q  <= kcur_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule
